/* sv/vqda_pkg.sv */
// Shared opcodes, error codes and free-map control types for the descriptor allocator.
package vqda_pkg;

    localparam logic [1:0] OP_ALLOC_ONE   = 2'd0;
    localparam logic [1:0] OP_ALLOC_THREE = 2'd1;
    localparam logic [1:0] OP_FREE_ONE    = 2'd2;
    localparam logic [1:0] OP_FREE_CHAIN  = 2'd3;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_EMPTY = 2'd1;
    localparam logic [1:0] ERR_RANGE = 2'd2;
    localparam logic [1:0] ERR_FREE  = 2'd3;

    typedef struct packed {
        logic       clear;      // restart search: drop picks, back to group zero
        logic       take;       // mark current hit as picked
        logic       advance;    // move to next group
        logic       commit;     // picked descriptors become allocated
        logic       release_en; // descriptor at idx becomes free
        logic [7:0] idx;        // query / release index
    } t_fm_cmd;

    typedef struct packed {
        logic       hit;
        logic [7:0] hit_idx;
        logic       last_grp;
        logic       query_free;
    } t_fm_stat;

endpackage

/* sv/vqda_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module vqda_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/vqda_freemap.sv */
// Free map flops with a group-at-a-time lowest-free search and pick mask.
module vqda_freemap #(
    parameter int DESC_COUNT = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vqda_pkg::t_fm_cmd  i_cmd,
    output vqda_pkg::t_fm_stat o_stat
);

    localparam int IW    = $clog2(DESC_COUNT);
    localparam int FM_N  = 2 ** IW;
    localparam int GRP_W = (DESC_COUNT < 32) ? DESC_COUNT : 32;
    localparam int NGRP  = (DESC_COUNT + GRP_W - 1) / GRP_W;
    localparam int GIW   = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int EW    = $clog2(GRP_W);

    logic [FM_N-1:0]  r_free;
    logic [FM_N-1:0]  r_pick;
    logic [GIW-1:0]   r_grp;
    logic [FM_N-1:0]  cand;
    logic [GRP_W-1:0] grp_bits;
    logic [EW-1:0]    enc;
    logic [7:0]       hit_idx;

    always_comb begin
        cand     = r_free & ~r_pick;
        grp_bits = cand[r_grp * GRP_W +: GRP_W];
        enc      = '0;
        for (int i = GRP_W - 1; i >= 0; i--) begin
            if (grp_bits[i]) begin
                enc = EW'(i);
            end
        end
        hit_idx = 8'(int'(r_grp) * GRP_W + int'(enc));
    end

    assign o_stat.hit        = |grp_bits;
    assign o_stat.hit_idx    = hit_idx;
    assign o_stat.last_grp   = (r_grp == GIW'(NGRP - 1));
    assign o_stat.query_free = r_free[i_cmd.idx[IW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FM_N; i++) begin
                r_free[i] <= (i < DESC_COUNT);
            end
            r_pick <= '0;
            r_grp  <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_pick <= '0;
                r_grp  <= '0;
            end else begin
                if (i_cmd.take) begin
                    r_pick[hit_idx[IW-1:0]] <= 1'b1;
                end
                if (i_cmd.advance) begin
                    r_grp <= r_grp + 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_free <= r_free & ~r_pick;
            end else if (i_cmd.release_en) begin
                r_free[i_cmd.idx[IW-1:0]] <= 1'b1;
            end
        end
    end

endmodule

/* sv/virtqueue_descriptor_allocator.sv */
// Alloc searches the free map in S_SEARCH, a 32-descriptor group at a time, writes the last link
// and commits in S_TAIL and loads the result in S_DONE; frees visit descriptors in S_WALK, and a
// range error on a free goes straight to S_DONE. One item at a time: the next beat is taken the
// cycle after the result is registered. Chain walks do one link RAM read per descriptor, alloc
// one free-map pick per cycle while its group has a free one. Sync reset marks all descriptors free;
// the link RAM is not cleared, since every link is written when its descriptor is allocated.
module virtqueue_descriptor_allocator #(
    parameter int DESC_COUNT = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_desc_index,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_error_code,
    output logic [7:0] o_first_index,
    output logic [7:0] o_second_index,
    output logic [7:0] o_third_index,
    output logic [8:0] o_freed_count
);

    localparam int IW = $clog2(DESC_COUNT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_TAIL,
        S_WALK,
        S_DONE
    } t_state;

    t_state  r_state, n_state;
    logic [1:0]  r_op, n_op;
    logic [1:0]  r_err, n_err;
    logic [IW-1:0] r_k0, n_k0, r_k1, n_k1, r_k2, n_k2;
    logic [1:0]  r_npick, n_npick;
    logic [8:0]  r_cnt, n_cnt;
    logic [IW-1:0] r_cur, n_cur;
    logic        r_oval, n_oval;
    logic [1:0]  r_o_err, n_o_err;
    logic [7:0]  r_o_a, n_o_a, r_o_b, n_o_b, r_o_c, n_o_c;
    logic [8:0]  r_o_cnt, n_o_cnt;

    vqda_pkg::t_fm_cmd  fm_cmd;
    vqda_pkg::t_fm_stat fm_stat;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [IW:0]   ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [IW:0]   ram_rdata;
    logic          rd_has;
    logic [IW-1:0] rd_next;
    logic          load;

    assign rd_has  = ram_rdata[IW];
    assign rd_next = ram_rdata[IW-1:0];

    vqda_freemap #(.DESC_COUNT(DESC_COUNT)) u_freemap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (fm_cmd),
        .o_stat  (fm_stat)
    );

    vqda_ram #(.WIDTH(IW + 1), .DEPTH(DESC_COUNT)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_err     = r_err;
        n_k0      = r_k0;
        n_k1      = r_k1;
        n_k2      = r_k2;
        n_npick   = r_npick;
        n_cnt     = r_cnt;
        n_cur     = r_cur;
        fm_cmd    = '0;
        fm_cmd.idx = 8'(r_cur);
        ram_we    = 1'b0;
        ram_waddr = r_k0;
        ram_wdata = '0;
        ram_raddr = r_cur;
        load      = 1'b0;

        case (r_state)
            S_IDLE: begin
                ram_raddr = i_desc_index[IW-1:0];
                if (i_valid) begin
                    n_op    = i_opcode;
                    n_err   = vqda_pkg::ERR_OK;
                    n_k0    = '0;
                    n_k1    = '0;
                    n_k2    = '0;
                    n_npick = '0;
                    n_cnt   = '0;
                    n_cur   = i_desc_index[IW-1:0];
                    if (i_opcode == vqda_pkg::OP_ALLOC_ONE ||
                        i_opcode == vqda_pkg::OP_ALLOC_THREE) begin
                        fm_cmd.clear = 1'b1;
                        n_state      = S_SEARCH;
                    end else if ({1'b0, i_desc_index} < 9'(DESC_COUNT)) begin
                        n_state = S_WALK;
                    end else begin
                        n_err   = vqda_pkg::ERR_RANGE;
                        n_state = S_DONE;
                    end
                end
            end
            S_SEARCH: begin
                if (fm_stat.hit) begin
                    fm_cmd.take = 1'b1;
                    ram_wdata   = {1'b1, fm_stat.hit_idx[IW-1:0]};
                    case (r_npick)
                        2'd0: begin
                            n_k0 = fm_stat.hit_idx[IW-1:0];
                        end
                        2'd1: begin
                            n_k1      = fm_stat.hit_idx[IW-1:0];
                            ram_we    = 1'b1;
                            ram_waddr = r_k0;
                        end
                        default: begin
                            n_k2      = fm_stat.hit_idx[IW-1:0];
                            ram_we    = 1'b1;
                            ram_waddr = r_k1;
                        end
                    endcase
                    if (r_op == vqda_pkg::OP_ALLOC_ONE || r_npick == 2'd2) begin
                        n_state = S_TAIL;
                    end else begin
                        n_npick = r_npick + 2'd1;
                    end
                end else if (fm_stat.last_grp) begin
                    n_err   = vqda_pkg::ERR_EMPTY;
                    n_k0    = '0;
                    n_k1    = '0;
                    n_k2    = '0;
                    n_state = S_DONE;
                end else begin
                    fm_cmd.advance = 1'b1;
                end
            end
            S_TAIL: begin
                ram_we        = 1'b1;
                ram_waddr     = (r_op == vqda_pkg::OP_ALLOC_ONE) ? r_k0 : r_k2;
                ram_wdata     = '0;
                fm_cmd.commit = 1'b1;
                n_state       = S_DONE;
            end
            S_WALK: begin
                if (fm_stat.query_free) begin
                    n_err   = vqda_pkg::ERR_FREE;
                    n_state = S_DONE;
                end else begin
                    fm_cmd.release_en = 1'b1;
                    n_cnt             = r_cnt + 9'd1;
                    if (r_op == vqda_pkg::OP_FREE_CHAIN && rd_has) begin
                        if (9'(rd_next) < 9'(DESC_COUNT)) begin
                            n_cur     = rd_next;
                            ram_raddr = rd_next;
                        end else begin
                            n_err   = vqda_pkg::ERR_RANGE;
                            n_state = S_DONE;
                        end
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_oval || !i_stall) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_oval  = load ? 1'b1 : (i_stall ? r_oval : 1'b0);
        n_o_err = load ? r_err : r_o_err;
        n_o_a   = load ? 8'(r_k0) : r_o_a;
        n_o_b   = load ? 8'(r_k1) : r_o_b;
        n_o_c   = load ? 8'(r_k2) : r_o_c;
        n_o_cnt = load ? r_cnt : r_o_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_oval  <= n_oval;
        end
        r_op    <= n_op;
        r_err   <= n_err;
        r_k0    <= n_k0;
        r_k1    <= n_k1;
        r_k2    <= n_k2;
        r_npick <= n_npick;
        r_cnt   <= n_cnt;
        r_cur   <= n_cur;
        r_o_err <= n_o_err;
        r_o_a   <= n_o_a;
        r_o_b   <= n_o_b;
        r_o_c   <= n_o_c;
        r_o_cnt <= n_o_cnt;
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_oval;
    assign o_error_code   = r_o_err;
    assign o_first_index  = r_o_a;
    assign o_second_index = r_o_b;
    assign o_third_index  = r_o_c;
    assign o_freed_count  = r_o_cnt;

endmodule

/* sv/vqda_chk.sv */
// Port-level checker for the descriptor allocator and its bind.
module vqda_chk #(
    parameter int DESC_COUNT = 8
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_error_code,
    input logic [7:0] o_first_index,
    input logic [7:0] o_second_index,
    input logic [7:0] o_third_index,
    input logic [8:0] o_freed_count
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("accepted beat did not make the block busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_first_index) &&
                                  $stable(o_freed_count) && $stable(o_error_code)))
        else $error("stalled result beat changed");

    a_err_no_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error_code != vqda_pkg::ERR_OK && o_freed_count == 9'd0) |->
        (o_first_index == 8'd0 && o_second_index == 8'd0 && o_third_index == 8'd0))
        else $error("failed request reported descriptor indexes");

    a_free_no_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_freed_count != 9'd0) |->
        (o_first_index == 8'd0 && o_second_index == 8'd0 && o_third_index == 8'd0))
        else $error("free result carried allocation indexes");

    a_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_freed_count <= 9'(DESC_COUNT) &&
                     9'(o_first_index) < 9'(DESC_COUNT) &&
                     9'(o_third_index) < 9'(DESC_COUNT)))
        else $error("result index or count beyond pool size");

endmodule

bind virtqueue_descriptor_allocator vqda_chk #(.DESC_COUNT(DESC_COUNT)) u_vqda_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_error_code   (o_error_code),
    .o_first_index  (o_first_index),
    .o_second_index (o_second_index),
    .o_third_index  (o_third_index),
    .o_freed_count  (o_freed_count)
);
